// ----- rtl/u8tok_pkg.sv -----
package u8tok_pkg;

  localparam int VocabSizeDefault = 256;
  localparam logic [15:0] MaxTokensReset = 16'd1024;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StZero     = 2'd1;
  localparam logic [1:0] StBad      = 2'd2;
  localparam logic [1:0] StTooLong  = 2'd3;

  localparam logic [1:0] PadNone = 2'd0;
  localparam logic [1:0] PadInter = 2'd1;
  localparam logic [1:0] PadWrap = 2'd2;

  localparam logic [1:0] BoundNone = 2'd0;
  localparam logic [1:0] BoundLow  = 2'd1;
  localparam logic [1:0] BoundHigh = 2'd2;

  localparam logic [1:0] RegPadding = 2'd0;
  localparam logic [1:0] RegBlank   = 2'd1;
  localparam logic [1:0] RegMax     = 2'd2;

  // One result: token, status, last.
  typedef struct packed {
    logic [7:0] token;
    logic [1:0] status;
    logic       last;
  } result_t;

endpackage

// ----- rtl/u8tok_ram.sv -----
module u8tok_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/u8tok_scan.sv -----
module u8tok_scan #(
  parameter int VocabSize = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [20:0]                  scalar,
  input  logic [VocabSize-1:0]         valid_bits,
  output logic [$clog2(VocabSize)-1:0] raddr,
  input  logic [20:0]                  rdata,
  output logic                         done,
  output logic                         found,
  output logic [$clog2(VocabSize)-1:0] found_id
);

  localparam int Aw = $clog2(VocabSize);
  localparam logic [Aw-1:0] TopIdx = Aw'(VocabSize - 1);

  // Walks the table from the highest id down; the compare unit checks the
  // entry read in the previous cycle.
  logic          busy;
  logic [Aw-1:0] cmp_idx;

  assign raddr = (start) ? TopIdx : cmp_idx - Aw'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      found <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cmp_idx <= TopIdx;
        found <= 1'b0;
      end else if (busy) begin
        if (valid_bits[cmp_idx] && rdata == scalar) begin
          busy <= 1'b0;
          done <= 1'b1;
          found <= 1'b1;
          found_id <= cmp_idx;
        end else if (cmp_idx == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cmp_idx <= cmp_idx - Aw'(1);
        end
      end
    end
  end

endmodule

// ----- rtl/utf8_symbol_tokenizer_core.sv -----
// A text byte that completes a code point walks the vocabulary memory from
// the highest id down, one entry per cycle through a single compare unit,
// before its results are sent. One item is worked on at a time: a load or
// a text byte is accepted only in the idle state. Reset (rst, synchronous)
// clears control state and the valid bits; the code point memory is not
// cleared.
module utf8_symbol_tokenizer_core #(
  parameter int VOCAB_SIZE = u8tok_pkg::VocabSizeDefault
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata, low bit up: op, text_byte, entry_index, entry_scalar, entry_used,
  // then zero fill to 40 bits.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        s_tlast,
  // m_tdata, low bit up: token, status, then zero fill to 16 bits.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import u8tok_pkg::*;

  localparam int Aw = $clog2(VOCAB_SIZE);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_SCAN = 5'b00100,
    S_WAIT = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [1:0]  padding_mode;
  logic [7:0]  pad_token;
  logic [15:0] max_tokens;

  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      RegPadding: prdata = {30'd0, padding_mode};
      RegBlank:   prdata = {24'd0, pad_token};
      RegMax:     prdata = {16'd0, max_tokens};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      padding_mode <= PadNone;
      pad_token <= '0;
      max_tokens <= MaxTokensReset;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        RegPadding: padding_mode <= pwdata[1:0];
        RegBlank:   pad_token <= pwdata[7:0];
        RegMax:     max_tokens <= pwdata[15:0];
        default:    ;
      endcase
    end
  end

  // Input fields.
  logic        in_op;
  logic [7:0]  in_byte;
  logic [7:0]  in_index;
  logic [20:0] in_scalar;
  logic        in_used;
  assign in_op = s_tdata[0];
  assign in_byte = s_tdata[8:1];
  assign in_index = s_tdata[16:9];
  assign in_scalar = s_tdata[37:17];
  assign in_used = s_tdata[38];

  logic unused_pad;
  assign unused_pad = s_tdata[39];

  logic accept;
  assign s_tready = (state == S_IDLE);
  assign accept = s_tvalid && s_tready;

  // Vocabulary: code points in memory, valid bits in flip-flops.
  logic                  load_ok;
  logic [VOCAB_SIZE-1:0] entry_valid;
  logic [Aw-1:0]         scan_raddr;
  logic [20:0]           ram_rdata;

  generate
    if (VOCAB_SIZE >= 256) begin : g_idx_full
      assign load_ok = 1'b1;
    end else begin : g_idx_cmp
      assign load_ok = ({1'b0, in_index} < 9'(VOCAB_SIZE));
    end
  endgenerate

  logic          load_we;
  logic [Aw-1:0] load_addr;
  assign load_we = accept && !in_op && load_ok;
  assign load_addr = Aw'({{Aw{1'b0}}, in_index});

  u8tok_ram #(.Width(21), .Depth(VOCAB_SIZE)) u_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_addr),
    .wdata (in_scalar),
    .raddr (scan_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (load_we) begin
      entry_valid[load_addr] <= in_used;
    end
  end

  // Sequence state.
  logic [1:0]  bytes_pending;
  logic [20:0] partial_scalar;
  logic [1:0]  second_byte_bound;
  logic        sequence_started;
  logic [15:0] tokens_emitted;
  logic        discarding;

  logic [7:0]  cur_byte;
  logic        cur_last;
  logic [20:0] scalar;

  // Pending results, up to three.
  result_t     res [3];
  logic [1:0]  res_n;
  logic [1:0]  res_i;
  logic        lead_blank;

  logic       scan_start;
  logic       scan_done;
  logic       scan_found;
  logic [Aw-1:0] scan_id;

  u8tok_scan #(.VocabSize(VOCAB_SIZE)) u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (scan_start),
    .scalar     (scalar),
    .valid_bits (entry_valid),
    .raddr      (scan_raddr),
    .rdata      (ram_rdata),
    .done       (scan_done),
    .found      (scan_found),
    .found_id   (scan_id)
  );

  logic interleave, wrap;
  assign interleave = (padding_mode == PadInter);
  assign wrap = (padding_mode == PadWrap);

  // Decode step, combinational on the held byte.
  typedef struct packed {
    logic        err;
    logic [1:0]  st;
    logic        lead;
    logic        done;
    logic [1:0]  pend;
    logic [20:0] part;
    logic [1:0]  bound;
    logic [20:0] scal;
  } dec_t;

  dec_t d;
  logic [7:0] lo_b, hi_b;
  always_comb begin
    d = '0;
    d.pend = bytes_pending;
    d.part = partial_scalar;
    d.bound = second_byte_bound;
    lo_b = (bytes_pending == 2'd2) ? 8'ha0 : 8'h90;
    hi_b = (bytes_pending == 2'd2) ? 8'h9f : 8'h8f;
    if (!sequence_started) begin
      if (max_tokens == 16'd0) begin
        d.err = 1'b1;
        d.st = StZero;
      end else if (wrap && max_tokens < 16'd2) begin
        d.err = 1'b1;
        d.st = StTooLong;
      end else if (interleave || wrap) begin
        d.lead = 1'b1;
      end
    end
    if (!d.err) begin
      if (bytes_pending == 2'd0) begin
        if (cur_byte <= 8'h7f) begin
          d.scal = {13'd0, cur_byte};
          d.done = 1'b1;
        end else if (cur_byte >= 8'hc2 && cur_byte <= 8'hdf) begin
          d.pend = 2'd1;
          d.part = {16'd0, cur_byte[4:0]};
        end else if (cur_byte >= 8'he0 && cur_byte <= 8'hef) begin
          d.pend = 2'd2;
          d.part = {17'd0, cur_byte[3:0]};
          d.bound = (cur_byte == 8'he0) ? BoundLow :
                    (cur_byte == 8'hed) ? BoundHigh : BoundNone;
        end else if (cur_byte >= 8'hf0 && cur_byte <= 8'hf4) begin
          d.pend = 2'd3;
          d.part = {18'd0, cur_byte[2:0]};
          d.bound = (cur_byte == 8'hf0) ? BoundLow :
                    (cur_byte == 8'hf4) ? BoundHigh : BoundNone;
        end else begin
          d.err = 1'b1;
          d.st = StBad;
        end
      end else begin
        if (cur_byte[7:6] != 2'b10) begin
          d.err = 1'b1;
          d.st = StBad;
        end else if (second_byte_bound == BoundLow && cur_byte < lo_b) begin
          d.err = 1'b1;
          d.st = StBad;
        end else if (second_byte_bound == BoundHigh && cur_byte > hi_b) begin
          d.err = 1'b1;
          d.st = StBad;
        end else begin
          d.bound = BoundNone;
          d.part = {partial_scalar[14:0], cur_byte[5:0]};
          d.pend = bytes_pending - 2'd1;
          if (d.pend == 2'd0) begin
            d.scal = d.part;
            d.part = '0;
            d.done = 1'b1;
          end
        end
      end
      if (!d.done && cur_last && d.pend != 2'd0) begin
        d.err = 1'b1;
        d.st = StBad;
      end
    end
  end

  // Budget check after a match. The budget is kept one bit wider so that a
  // budget below the reserved trailing blank wraps to a very large value.
  logic [15:0] add16, te_base;
  logic [16:0] budget, room;
  logic        over;
  always_comb begin
    add16 = interleave ? 16'd2 : 16'd1;
    budget = {1'b0, max_tokens} - (wrap ? 17'd1 : 17'd0);
    te_base = lead_blank ? 16'd1 : tokens_emitted;
    room = budget - {1'b0, te_base};
    over = ({1'b0, te_base} > budget) || ({1'b0, add16} > room);
  end

  function automatic result_t mk(input logic [7:0] t, input logic [1:0] s,
                                 input logic l);
    result_t r;
    r.token = t;
    r.status = s;
    r.last = l;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bytes_pending <= '0;
      partial_scalar <= '0;
      second_byte_bound <= BoundNone;
      sequence_started <= 1'b0;
      tokens_emitted <= '0;
      discarding <= 1'b0;
      res_n <= '0;
      res_i <= '0;
      lead_blank <= 1'b0;
      scan_start <= 1'b0;
    end else begin
      scan_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && in_op) begin
            if (discarding) begin
              if (s_tlast) begin
                discarding <= 1'b0;
              end
            end else begin
              cur_byte <= in_byte;
              cur_last <= s_tlast;
              state <= S_DEC;
            end
          end
        end
        S_DEC: begin
          res_i <= '0;
          lead_blank <= d.lead;
          if (d.err) begin
            res[0] <= mk(8'd0, d.st, 1'b1);
            res_n <= 2'd1;
            discarding <= !cur_last;
            bytes_pending <= '0;
            partial_scalar <= '0;
            second_byte_bound <= BoundNone;
            sequence_started <= 1'b0;
            tokens_emitted <= '0;
            state <= S_EMIT;
          end else begin
            sequence_started <= 1'b1;
            if (d.lead) begin
              tokens_emitted <= 16'd1;
            end
            bytes_pending <= d.pend;
            partial_scalar <= d.part;
            second_byte_bound <= d.bound;
            if (d.done) begin
              scalar <= d.scal;
              scan_start <= 1'b1;
              state <= S_SCAN;
            end else begin
              // No code point this step, so the byte cannot be the last one
              // here: only the lead blank can be due.
              res[0] <= mk(pad_token, StOk, cur_last && !wrap);
              res[1] <= mk(pad_token, StOk, cur_last);
              res_n <= 2'(d.lead) + 2'(cur_last && wrap);
              state <= (d.lead || (cur_last && wrap)) ? S_EMIT : S_IDLE;
            end
          end
        end
        S_SCAN: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (scan_done) begin
            state <= S_EMIT;
            if (!scan_found || over) begin
              res[0] <= mk(8'd0, scan_found ? StTooLong : StBad, 1'b1);
              res_n <= 2'd1;
              discarding <= !cur_last;
              bytes_pending <= '0;
              partial_scalar <= '0;
              second_byte_bound <= BoundNone;
              sequence_started <= 1'b0;
              tokens_emitted <= '0;
            end else begin
              if (lead_blank) begin
                res[0] <= mk(pad_token, StOk, 1'b0);
                res[1] <= mk(8'(scan_id), StOk, cur_last && !interleave && !wrap);
                res[2] <= mk(pad_token, StOk, cur_last);
                res_n <= (interleave || cur_last) ? 2'd3 : 2'd2;
              end else begin
                res[0] <= mk(8'(scan_id), StOk, cur_last && !interleave && !wrap);
                res[1] <= mk(pad_token, StOk, cur_last);
                res_n <= (interleave || (cur_last && wrap)) ? 2'd2 : 2'd1;
              end
              if (cur_last) begin
                sequence_started <= 1'b0;
                tokens_emitted <= '0;
              end else begin
                tokens_emitted <= te_base + add16;
              end
            end
          end
        end
        S_EMIT: begin
          if (m_tready) begin
            if (res_i + 2'd1 == res_n) begin
              state <= S_IDLE;
            end
            res_i <= res_i + 2'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  result_t cur_res;
  always_comb begin
    cur_res = res[0];
    case (res_i)
      2'd1: cur_res = res[1];
      2'd2: cur_res = res[2];
      default: cur_res = res[0];
    endcase
  end

  assign m_tvalid = (state == S_EMIT);
  assign m_tdata = {6'd0, cur_res.status, cur_res.token};
  assign m_tlast = cur_res.last;

`ifndef SYNTHESIS
  // The input side stays closed while results are pending.
  a_no_accept_emit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input open during result delivery");
  // An error result always ends the sequence.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[9:8] != StOk) |-> m_tlast)
    else $error("error result without last");
  // An error result carries token zero.
  a_err_tok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[9:8] != StOk) |-> (m_tdata[7:0] == 8'd0))
    else $error("error result with nonzero token");
`endif

endmodule
